// ===== sv/bsrt_pkg.sv =====
package bsrt_pkg;

   localparam int ENTRIES    = 1024;
   localparam int MAX_RANGE  = 32;
   localparam int AW         = $clog2(ENTRIES);
   localparam int CW         = AW + 1;
   localparam logic [CW-1:0] CAP_RESET = CW'(ENTRIES);

   typedef enum logic [2:0] {
      MODE_ADD    = 3'd0,
      MODE_REMOVE = 3'd1,
      MODE_CHANGE = 3'd2,
      MODE_SET    = 3'd3,
      MODE_RANK   = 3'd4,
      MODE_RANGE  = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_EXISTS    = 3'd2,
      ST_BELOW_MIN = 3'd3,
      ST_NO_CHANGE = 3'd4,
      ST_BAD_RANGE = 3'd5
   } status_type;

   // walk the datapath pointer does over the memory
   typedef enum logic [1:0] {
      OP_FIND = 2'd0,
      OP_PULL = 2'd1,
      OP_SEEK = 2'd2,
      OP_PUSH = 2'd3
   } scan_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND,
      S_DECIDE,
      S_REMOVE,
      S_SEEK,
      S_SHIFT,
      S_PLACE,
      S_RESULT,
      S_RANGE,
      S_RANGE_OUT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       scan_start;
      logic       remove_start;
      logic       seek_start;
      logic       shift_start;
      logic       place;
      logic       evict;
      logic       range_start;
      logic       range_next;
      logic       result_load;
      status_type result_status;
      logic       result_last;
   } cmd_type;

   typedef struct packed {
      logic       busy;
      logic       found;
      logic [2:0] mode;
      logic       full;
      logic       below_min;
      logic       no_change;
      logic       bad_range;
      logic       range_last;
      logic       out_free;
   } sts_type;

endpackage

// ===== sv/bsrt_if.sv =====
interface bsrt_req_if;
   import bsrt_pkg::*;
   logic        valid;
   logic        ready;
   logic [2:0]  mode;
   logic [31:0] key;
   logic [31:0] new_value;
   logic signed [31:0] delta;
   logic [10:0] range_begin;
   logic [5:0]  range_count;
   modport source (output valid, mode, key, new_value, delta, range_begin, range_count,
                   input ready);
   modport sink   (input valid, mode, key, new_value, delta, range_begin, range_count,
                   output ready);
endinterface

interface bsrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [10:0] old_rank;
   logic [10:0] new_rank;
   logic [31:0] entry_key;
   logic [31:0] entry_value;
   logic [10:0] total_count;
   logic        last_result;
   modport source (output valid, status, old_rank, new_rank, entry_key, entry_value,
                   total_count, last_result, input ready);
   modport sink   (input valid, status, old_rank, new_rank, entry_key, entry_value,
                   total_count, last_result, output ready);
endinterface

// ===== sv/bsrt_datapath.sv =====
module bsrt_datapath
   import bsrt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cmd_type        cmd,
   output sts_type        sts,
   input  logic           csr_write,
   input  logic [10:0]    csr_data,
   input  logic [2:0]     in_mode,
   input  logic [31:0]    in_key,
   input  logic [31:0]    in_new_value,
   input  logic [31:0]    in_delta,
   input  logic [10:0]    in_range_begin,
   input  logic [5:0]     in_range_count,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [2:0]     out_status,
   output logic [10:0]    out_old_rank,
   output logic [10:0]    out_new_rank,
   output logic [31:0]    out_entry_key,
   output logic [31:0]    out_entry_value,
   output logic [10:0]    out_total_count,
   output logic           out_last_result
);

   // entry memory, key and value packed per word
   logic [63:0] mem [ENTRIES];
   logic [63:0] rd_ff;
   logic [AW-1:0] raddr;
   logic          wen;
   logic [AW-1:0] waddr;
   logic [63:0]   wdata;

   always_ff @(posedge clock) begin
      if (wen) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   logic [10:0]   cap_ff;
   logic [CW-1:0] count_ff;
   logic [2:0]    mode_ff;
   logic [31:0]   key_ff, nv_ff, delta_ff, val_ff, nv_in;
   logic [10:0]   rb_ff;
   logic [5:0]    rc_ff;
   logic [CW-1:0] idx_ff;            // scan pointer
   logic [CW-1:0] pos_ff;            // found position
   logic [CW-1:0] ins_ff;            // insert position
   logic [CW-1:0] end_ff;            // last index of range
   logic          act_ff;            // scan/shift running
   logic          rdv_ff;            // read data in rd_ff is valid, for index rdi_ff
   logic          found_ff;
   scan_op_type   op_ff;             // find, pull down, seek, push up
   logic [CW-1:0] eff_cap;

   always_comb begin
      eff_cap = CW'(cap_ff);
      if (cap_ff == 11'd0) eff_cap = CW'(1);
      if (CW'(cap_ff) > CW'(ENTRIES)) eff_cap = CW'(ENTRIES);
   end

   // the read data in rd_ff belongs to index rdi_ff
   logic [CW-1:0] rdi_ff;
   logic [31:0]   rd_key, rd_val;
   assign rd_key = rd_ff[63:32];
   assign rd_val = rd_ff[31:0];

   logic [32:0] sum_w;
   logic [31:0] mag_w;
   assign sum_w = {1'b0, val_ff} + {1'b0, delta_ff};
   assign mag_w = ~delta_ff + 32'd1;

   // output register
   logic          ov_ff;
   logic [2:0]    ost_ff;
   logic [10:0]   oor_ff, onr_ff, otc_ff;
   logic [31:0]   ok_ff, ovl_ff;
   logic          ol_ff;

   always_comb begin
      raddr = idx_ff[AW-1:0];
      wen   = 1'b0;
      waddr = idx_ff[AW-1:0];
      wdata = rd_ff;
      if (cmd.place) begin
         wen   = 1'b1;
         waddr = ins_ff[AW-1:0];
         wdata = {key_ff, nv_ff};
      end else if (act_ff && rdv_ff && op_ff == OP_PULL) begin
         // pull entry down by one
         wen   = 1'b1;
         waddr = AW'(rdi_ff - CW'(1));
      end else if (act_ff && rdv_ff && op_ff == OP_PUSH) begin
         wen   = 1'b1;
         waddr = AW'(rdi_ff + CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= 11'(CAP_RESET);
         count_ff <= '0;
         act_ff   <= 1'b0;
         rdv_ff   <= 1'b0;
         ov_ff    <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         if (csr_write) cap_ff <= csr_data;
         if (ov_ff && out_ready) ov_ff <= 1'b0;
         rdv_ff <= 1'b0;
         rdi_ff <= idx_ff;
         if (cmd.load) begin
            mode_ff  <= in_mode;
            key_ff   <= in_key;
            nv_ff    <= in_new_value;
            delta_ff <= in_delta;
            rb_ff    <= in_range_begin;
            rc_ff    <= in_range_count;
         end
         if (cmd.scan_start) begin
            idx_ff   <= '0;
            op_ff    <= OP_FIND;
            found_ff <= 1'b0;
            pos_ff   <= count_ff;
            act_ff   <= (count_ff != '0);
         end else if (cmd.remove_start) begin
            idx_ff <= pos_ff + CW'(1);
            op_ff  <= OP_PULL;
            act_ff <= (pos_ff + CW'(1) < count_ff);
            count_ff <= count_ff - CW'(1);
         end else if (cmd.evict) begin
            count_ff <= count_ff - CW'(1);
         end else if (cmd.seek_start) begin
            idx_ff <= '0;
            op_ff  <= OP_SEEK;
            ins_ff <= count_ff;
            act_ff <= (count_ff != '0);
         end else if (cmd.shift_start) begin
            idx_ff <= count_ff - CW'(1);
            op_ff  <= OP_PUSH;
            act_ff <= (count_ff != ins_ff);
         end else if (cmd.place) begin
            count_ff <= count_ff + CW'(1);
         end else if (act_ff) begin
            rdv_ff <= 1'b1;
            case (op_ff)
               OP_FIND: begin
                  // issue read, compare data from previous cycle
                  if (rdv_ff && rd_key == key_ff) begin
                     found_ff <= 1'b1;
                     pos_ff   <= rdi_ff;
                     val_ff   <= rd_val;
                     act_ff   <= 1'b0;
                     rdv_ff   <= 1'b0;
                  end else if (idx_ff == count_ff) begin
                     // park on the last entry so its value is at hand for a full add
                     idx_ff <= count_ff - CW'(1);
                     act_ff <= 1'b0;
                     rdv_ff <= 1'b0;
                  end else begin
                     idx_ff <= idx_ff + CW'(1);
                  end
               end
               OP_PULL: begin
                  if (idx_ff == count_ff + CW'(1)) begin
                     act_ff <= 1'b0;
                     rdv_ff <= 1'b0;
                  end else begin
                     idx_ff <= idx_ff + CW'(1);
                  end
               end
               OP_SEEK: begin
                  if (rdv_ff && rd_val < nv_ff) begin
                     ins_ff <= rdi_ff;
                     act_ff <= 1'b0;
                     rdv_ff <= 1'b0;
                  end else if (idx_ff == count_ff) begin
                     act_ff <= 1'b0;
                     rdv_ff <= 1'b0;
                  end else begin
                     idx_ff <= idx_ff + CW'(1);
                  end
               end
               default: begin
                  if (rdv_ff && rdi_ff == ins_ff) begin
                     act_ff <= 1'b0;
                     rdv_ff <= 1'b0;
                  end else begin
                     idx_ff <= idx_ff - CW'(1);
                  end
               end
            endcase
         end
         if (cmd.range_start) begin
            idx_ff <= CW'(rb_ff) - CW'(1);
            end_ff <= CW'(rb_ff) - CW'(1) + ((CW'(rc_ff) > CW'(MAX_RANGE)) ?
                      CW'(MAX_RANGE) : CW'(rc_ff)) - CW'(1);
            if (CW'(rb_ff) - CW'(1) + ((CW'(rc_ff) > CW'(MAX_RANGE)) ? CW'(MAX_RANGE)
                : CW'(rc_ff)) > count_ff)
               end_ff <= count_ff - CW'(1);
         end
         if (cmd.range_next) idx_ff <= idx_ff + CW'(1);
         if (cmd.result_load) begin
            ov_ff  <= 1'b1;
            ost_ff <= cmd.result_status;
            ol_ff  <= cmd.result_last;
            otc_ff <= 11'(count_ff);
            ok_ff  <= key_ff;
            oor_ff <= 11'd0;
            onr_ff <= 11'd0;
            ovl_ff <= 32'd0;
            case (mode_type'(mode_ff))
               MODE_ADD: begin
                  ovl_ff <= nv_ff;
                  if (cmd.result_status == ST_EXISTS) begin
                     oor_ff <= 11'(pos_ff + CW'(1));
                     onr_ff <= 11'(pos_ff + CW'(1));
                     ovl_ff <= val_ff;
                  end else if (cmd.result_status == ST_OK) begin
                     onr_ff <= 11'(ins_ff + CW'(1));
                  end
               end
               MODE_REMOVE: begin
                  if (found_ff) begin
                     oor_ff <= 11'(pos_ff + CW'(1));
                     ovl_ff <= val_ff;
                  end
               end
               MODE_CHANGE, MODE_SET: begin
                  if (found_ff) begin
                     oor_ff <= 11'(pos_ff + CW'(1));
                     if (cmd.result_status == ST_NO_CHANGE) begin
                        onr_ff <= 11'(pos_ff + CW'(1));
                        ovl_ff <= val_ff;
                     end else begin
                        onr_ff <= 11'(ins_ff + CW'(1));
                        ovl_ff <= nv_ff;
                     end
                  end
               end
               MODE_RANK: begin
                  if (found_ff) begin
                     oor_ff <= 11'(pos_ff + CW'(1));
                     onr_ff <= 11'(pos_ff + CW'(1));
                     ovl_ff <= val_ff;
                  end
               end
               MODE_RANGE: begin
                  ok_ff <= 32'd0;
                  if (cmd.result_status == ST_OK) begin
                     onr_ff <= 11'(rdi_ff + CW'(1));
                     ok_ff  <= rd_key;
                     ovl_ff <= rd_val;
                  end
               end
               default: ;
            endcase
         end
         // compute new value once the entry is found (change / set)
         if (cmd.remove_start && (mode_ff == MODE_CHANGE || mode_ff == MODE_SET))
            nv_ff <= nv_in;
      end
   end

   always_comb begin
      nv_in = nv_ff;
      if (mode_ff == MODE_CHANGE) begin
         if (delta_ff[31]) nv_in = (val_ff < mag_w) ? 32'd0 : val_ff - mag_w;
         else nv_in = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
      end
   end

   assign sts.busy       = act_ff;
   assign sts.found      = found_ff;
   assign sts.mode       = mode_ff;
   assign sts.full       = (count_ff >= eff_cap);
   assign sts.below_min  = (nv_ff <= rd_val);
   assign sts.no_change  = (mode_ff == MODE_CHANGE) ?
                           (delta_ff == 32'd0 || (!delta_ff[31] && val_ff == 32'hFFFF_FFFF)) :
                           (nv_ff == val_ff);
   assign sts.bad_range  = (rb_ff == 11'd0) || (rc_ff == 6'd0) || (CW'(rb_ff) > count_ff);
   assign sts.range_last = (idx_ff == end_ff);
   assign sts.out_free   = !ov_ff || out_ready;

   assign out_valid       = ov_ff;
   assign out_status      = ost_ff;
   assign out_old_rank    = oor_ff;
   assign out_new_rank    = onr_ff;
   assign out_entry_key   = ok_ff;
   assign out_entry_value = ovl_ff;
   assign out_total_count = otc_ff;
   assign out_last_result = ol_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ENTRIES)) else $error("count above depth");
   a_place_room: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> count_ff < CW'(ENTRIES)) else $error("insert into full memory");
   a_ins_range: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> ins_ff <= count_ff) else $error("insert past end");

endmodule

// ===== sv/bsrt_ctrl.sv =====
module bsrt_ctrl
   import bsrt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic [1:0] wait_ff, wait_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      wait_in  = '0;
      cmd      = '0;
      cmd.result_status = ST_OK;
      in_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            if (sts.mode == MODE_RANGE) begin
               state_in = S_RANGE;
            end else if (sts.mode > MODE_RANGE) begin
               state_in = S_IDLE;
            end else begin
               cmd.scan_start = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // wait for the key scan to finish
            if (!sts.busy && wait_ff != 2'd0 && sts.out_free) begin
               state_in = S_RESULT;
               case (mode_type'(sts.mode))
                  MODE_ADD: begin
                     if (sts.found) begin
                        cmd.result_load = 1'b1;
                        cmd.result_status = ST_EXISTS;
                        cmd.result_last = 1'b1;
                        state_in = S_IDLE;
                     end else state_in = S_REMOVE;
                  end
                  MODE_REMOVE: begin
                     if (!sts.found) begin
                        cmd.result_load = 1'b1;
                        cmd.result_status = ST_NOT_FOUND;
                        cmd.result_last = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        cmd.remove_start = 1'b1;
                        state_in = S_PLACE;
                     end
                  end
                  MODE_RANK: begin
                     cmd.result_load = 1'b1;
                     cmd.result_status = sts.found ? ST_OK : ST_NOT_FOUND;
                     cmd.result_last = 1'b1;
                     state_in = S_IDLE;
                  end
                  default: begin
                     if (!sts.found) begin
                        cmd.result_load = 1'b1;
                        cmd.result_status = ST_NOT_FOUND;
                        cmd.result_last = 1'b1;
                        state_in = S_IDLE;
                     end else if (sts.no_change) begin
                        cmd.result_load = 1'b1;
                        cmd.result_status = ST_NO_CHANGE;
                        cmd.result_last = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        cmd.remove_start = 1'b1;
                        state_in = S_SEEK;
                     end
                  end
               endcase
            end else if (wait_ff == 2'd0) wait_in = 2'd1;
            else wait_in = wait_ff;
         end
         S_REMOVE: begin
            // add path: check room, last entry read comes out of the scan
            if (sts.full) begin
               if (sts.below_min) begin
                  cmd.result_load = 1'b1;
                  cmd.result_status = ST_BELOW_MIN;
                  cmd.result_last = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.evict = 1'b1;
                  state_in = S_SEEK;
               end
            end else state_in = S_SEEK;
         end
         S_SEEK: begin
            // wait for the remove shift, then start the position search
            if (!sts.busy && wait_ff != 2'd0) begin
               cmd.seek_start = 1'b1;
               state_in = S_SHIFT;
            end else wait_in = 2'd1;
         end
         S_SHIFT: begin
            if (!sts.busy && wait_ff != 2'd0) begin
               cmd.shift_start = 1'b1;
               state_in = S_RESULT;
            end else wait_in = 2'd1;
         end
         S_RESULT: begin
            if (!sts.busy && wait_ff != 2'd0) begin
               cmd.place = 1'b1;
               state_in = S_PLACE;
               wait_in = 2'd2;
            end else wait_in = 2'd1;
         end
         S_PLACE: begin
            // final result once all shifting is done
            if (!sts.busy && wait_ff != 2'd0 && sts.out_free) begin
               cmd.result_load = 1'b1;
               cmd.result_last = 1'b1;
               state_in = S_IDLE;
            end else wait_in = 2'd1;
         end
         S_RANGE: begin
            if (sts.out_free) begin
               if (sts.bad_range) begin
                  cmd.result_load = 1'b1;
                  cmd.result_status = ST_BAD_RANGE;
                  cmd.result_last = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  cmd.range_start = 1'b1;
                  state_in = S_RANGE_OUT;
               end
            end
         end
         S_RANGE_OUT: begin
            // per entry: address it, then load the registered read data once the output is free
            if (wait_ff == 2'd0) wait_in = 2'd1;
            else if (wait_ff == 2'd1) wait_in = 2'd2;
            else if (sts.out_free) begin
               cmd.result_load = 1'b1;
               cmd.result_last = sts.range_last;
               if (sts.range_last) state_in = S_IDLE;
               else cmd.range_next = 1'b1;
            end else wait_in = wait_ff;
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      in_ready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_one_start: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.scan_start, cmd.remove_start, cmd.seek_start, cmd.shift_start,
                  cmd.place}) <= 1) else $error("two datapath commands at once");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> sts.out_free) else $error("result overwrite");

endmodule

// ===== sv/bounded_sorted_rank_table.sv =====
// bounded sorted rank table: keeps up to csr capacity (key, value) entries sorted by
// descending value in one 1024 x 64 single-port-write memory. one item at a time:
// a key lookup scans the table at one entry per cycle, and add, remove, change and
// set then shift entries by one place per cycle through the same memory. a rank query
// scans once, a remove also pulls the entries behind it down, and add, change and set
// also seek the new place and push entries up. range reads give their results one by
// one, each once the output register is free. the output register lets the last
// result wait while the block goes idle again.
module bounded_sorted_rank_table
   import bsrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   bsrt_req_if.sink    req,
   bsrt_rsp_if.source  rsp,
   input  logic        csr_write,
   input  logic [10:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // sequencer
   bsrt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   // storage, scan pointers and result register
   bsrt_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_write       (csr_write),
      .csr_data        (csr_data),
      .in_mode         (req.mode),
      .in_key          (req.key),
      .in_new_value    (req.new_value),
      .in_delta        (req.delta),
      .in_range_begin  (req.range_begin),
      .in_range_count  (req.range_count),
      .out_valid       (rsp.valid),
      .out_ready       (rsp.ready),
      .out_status      (rsp.status),
      .out_old_rank    (rsp.old_rank),
      .out_new_rank    (rsp.new_rank),
      .out_entry_key   (rsp.entry_key),
      .out_entry_value (rsp.entry_value),
      .out_total_count (rsp.total_count),
      .out_last_result (rsp.last_result)
   );

endmodule

// ===== dv/bounded_sorted_rank_table_tb.sv =====
module bounded_sorted_rank_table_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bsrt_pkg::*;

   localparam logic [31:0] VAL_MAX = 32'hFFFF_FFFF;
   localparam int DRAIN_WAIT = 3 * ENTRIES + 64;   // longest item plus margin

   // one request item as the sender sees it
   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] key;
      logic [31:0] new_value;
      logic [31:0] delta;
      logic [10:0] range_begin;
      logic [5:0]  range_count;
   } op_type;

   // one result item
   typedef struct packed {
      logic [2:0]  status;
      logic [10:0] old_rank;
      logic [10:0] new_rank;
      logic [31:0] entry_key;
      logic [31:0] entry_value;
      logic [10:0] total_count;
      logic        last_result;
   } result_type;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [10:0] csr_data;

   bsrt_req_if req_if();
   bsrt_rsp_if rsp_if();

   bounded_sorted_rank_table dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_write (csr_write),
      .csr_data  (csr_data)
   );

   // shadow leaderboard: keys and scores in rank order
   logic [31:0] board_key [0:ENTRIES-1];
   logic [31:0] board_val [0:ENTRIES-1];
   int          board_count;
   logic [10:0] capacity_reg;

   result_type  pending_results[$];
   int          error_count;
   int          items_sent;
   int          results_seen;
   bit          quiet_sender;    // no gaps between items
   bit          quiet_receiver;  // result side never stalls
   int          stall_left;

   // keys drawn mostly from a small pool so that collisions happen
   logic [31:0] key_pool [0:11] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3, 32'h10,
                                    32'h55AA_55AA, 32'hAA55_AA55, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h1234, 32'hBEEF};

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   function automatic int find_rank_pos(logic [31:0] k);
      for (int i = 0; i < board_count; i++)
         if (board_key[i] == k) return i;
      return board_count;
   endfunction

   function automatic void drop_at(int pos);
      for (int i = pos; i + 1 < board_count; i++) begin
         board_key[i] = board_key[i+1];
         board_val[i] = board_val[i+1];
      end
      board_count--;
   endfunction

   // new or moved entry lands after every entry of equal or greater score
   function automatic int place_entry(logic [31:0] k, logic [31:0] v);
      int pos;
      pos = 0;
      while (pos < board_count && board_val[pos] >= v) pos++;
      for (int i = board_count; i > pos; i--) begin
         board_key[i] = board_key[i-1];
         board_val[i] = board_val[i-1];
      end
      board_key[pos] = k;
      board_val[pos] = v;
      board_count++;
      return pos;
   endfunction

   function automatic void expect_result(logic [2:0] st, int orank, int nrank,
                                         logic [31:0] k, logic [31:0] v, logic last);
      result_type r;
      r.status      = st;
      r.old_rank    = 11'(orank);
      r.new_rank    = 11'(nrank);
      r.entry_key   = k;
      r.entry_value = v;
      r.total_count = 11'(board_count);
      r.last_result = last;
      pending_results = {pending_results, r};
   endfunction

   function automatic int effective_capacity();
      if (capacity_reg == 0) return 1;
      if (capacity_reg > ENTRIES) return ENTRIES;
      return capacity_reg;
   endfunction

   function automatic void predict_board(op_type o);
      int          pos;
      int          np;
      int          n;
      logic [31:0] cur;
      logic [31:0] nv;
      logic [31:0] mag;
      logic [32:0] sum;
      if (o.mode == MODE_RANGE) begin
         if (o.range_begin == 0 || o.range_count == 0 || o.range_begin > board_count) begin
            expect_result(ST_BAD_RANGE, 0, 0, 32'h0, 32'h0, 1'b1);
            return;
         end
         n = o.range_count;
         if (n > MAX_RANGE) n = MAX_RANGE;
         if (n > board_count - (o.range_begin - 1)) n = board_count - (o.range_begin - 1);
         for (int k = 0; k < n; k++)
            expect_result(ST_OK, 0, o.range_begin + k, board_key[o.range_begin-1+k],
                          board_val[o.range_begin-1+k], k + 1 == n);
         return;
      end
      if (o.mode > MODE_RANGE) return;   // unused modes give nothing

      pos = find_rank_pos(o.key);
      nv  = o.new_value;
      if (o.mode == MODE_ADD) begin
         if (pos < board_count) begin
            expect_result(ST_EXISTS, pos + 1, pos + 1, o.key, board_val[pos], 1'b1);
            return;
         end
         if (board_count >= effective_capacity()) begin
            if (nv <= board_val[board_count-1]) begin
               expect_result(ST_BELOW_MIN, 0, 0, o.key, nv, 1'b1);
               return;
            end
            board_count--;   // lowest entry evicted silently
         end
         np = place_entry(o.key, nv);
         expect_result(ST_OK, 0, np + 1, o.key, nv, 1'b1);
         return;
      end
      if (pos >= board_count) begin
         expect_result(ST_NOT_FOUND, 0, 0, o.key, 32'h0, 1'b1);
         return;
      end
      cur = board_val[pos];
      if (o.mode == MODE_REMOVE) begin
         drop_at(pos);
         expect_result(ST_OK, pos + 1, 0, o.key, cur, 1'b1);
         return;
      end
      if (o.mode == MODE_RANK) begin
         expect_result(ST_OK, pos + 1, pos + 1, o.key, cur, 1'b1);
         return;
      end
      if (o.mode == MODE_CHANGE) begin
         if (o.delta == 0 || (!o.delta[31] && cur == VAL_MAX)) begin
            expect_result(ST_NO_CHANGE, pos + 1, pos + 1, o.key, cur, 1'b1);
            return;
         end
         if (o.delta[31]) begin
            mag = ~o.delta + 32'd1;
            nv  = (cur < mag) ? 32'h0 : cur - mag;
         end else begin
            sum = {1'b0, cur} + {1'b0, o.delta};
            nv  = sum[32] ? VAL_MAX : sum[31:0];
         end
      end else if (nv == cur) begin
         expect_result(ST_NO_CHANGE, pos + 1, pos + 1, o.key, cur, 1'b1);
         return;
      end
      drop_at(pos);
      np = place_entry(o.key, nv);
      expect_result(ST_OK, pos + 1, np + 1, o.key, nv, 1'b1);
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", {21'h0, rsp_if.new_rank}, 32'h0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_if.status !== want.status)
               report_mismatch("status", rsp_if.status, want.status);
            if (rsp_if.old_rank !== want.old_rank)
               report_mismatch("old_rank", rsp_if.old_rank, want.old_rank);
            if (rsp_if.new_rank !== want.new_rank)
               report_mismatch("new_rank", rsp_if.new_rank, want.new_rank);
            if (rsp_if.entry_key !== want.entry_key)
               report_mismatch("entry_key", rsp_if.entry_key, want.entry_key);
            if (rsp_if.entry_value !== want.entry_value)
               report_mismatch("entry_value", rsp_if.entry_value, want.entry_value);
            if (rsp_if.total_count !== want.total_count)
               report_mismatch("total_count", rsp_if.total_count, want.total_count);
            if (rsp_if.last_result !== want.last_result)
               report_mismatch("last_result", rsp_if.last_result, want.last_result);
         end
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result-side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (!quiet_receiver && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_gap();
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- driving

   // holds valid high across back-to-back items, lowers it only for a gap
   task automatic send_item(op_type o);
      int gap;
      req_if.valid       <= 1'b1;
      req_if.mode        <= o.mode;
      req_if.key         <= o.key;
      req_if.new_value   <= o.new_value;
      req_if.delta       <= o.delta;
      req_if.range_begin <= o.range_begin;
      req_if.range_count <= o.range_count;
      do @(posedge clock); while (!req_if.ready);
      predict_board(o);
      items_sent++;
      gap = quiet_sender ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_op(logic [2:0] mode, logic [31:0] k, logic [31:0] nv,
                          logic [31:0] d, logic [10:0] rb, logic [5:0] rc);
      op_type o;
      o = '{mode, k, nv, d, rb, rc};
      send_item(o);
   endtask

   // all results in, then room for an item that gives no result to finish
   task automatic wait_quiet();
      int guard;
      req_if.valid <= 1'b0;
      guard = 0;
      while (pending_results.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_capacity(logic [10:0] cap);
      csr_write <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      csr_write <= 1'b0;
      capacity_reg = cap;
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic [31:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45 && board_count > 0) return board_key[$urandom_range(0, board_count - 1)];
      if (r < 85) return key_pool[$urandom_range(0, 11)];
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return VAL_MAX;
         2, 3:    return $urandom_range(1, 8);   // plenty of ties
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_delta();
      case ($urandom_range(0, 7))
         0:       return 32'h0;
         1:       return 32'h8000_0000;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'hFFFF_FFFF;
         4, 5:    return $urandom_range(1, 4);
         6:       return -$urandom_range(1, 4);
         default: return $urandom;
      endcase
   endfunction

   function automatic op_type pick_op();
      op_type o;
      int     r;
      o.key         = pick_key();
      o.new_value   = pick_value();
      o.delta       = pick_delta();
      o.range_count = 6'($urandom);
      r = $urandom_range(0, 9);
      if (r < 6) o.range_begin = 11'($urandom_range(1, board_count + 1));
      else if (r < 7) o.range_begin = 11'h0;
      else o.range_begin = 11'($urandom);
      r = $urandom_range(0, 99);
      if (r < 30) o.mode = MODE_ADD;
      else if (r < 43) o.mode = MODE_REMOVE;
      else if (r < 63) o.mode = MODE_CHANGE;
      else if (r < 73) o.mode = MODE_SET;
      else if (r < 83) o.mode = MODE_RANK;
      else if (r < 97) o.mode = MODE_RANGE;
      else o.mode = 3'($urandom_range(6, 7));
      return o;
   endfunction

   // every operation and corner on a three-entry table
   task automatic test_directed();
      write_capacity(11'd3);
      send_op(MODE_ADD,    32'h1, 32'd5, 0, 0, 0);
      send_op(MODE_ADD,    32'h1, 32'd9, 0, 0, 0);            // key already there
      send_op(MODE_ADD,    32'hFFFF_FFFF, VAL_MAX, 0, 0, 0);
      send_op(MODE_ADD,    32'h0, 32'd5, 0, 0, 0);            // tie goes behind
      send_op(MODE_ADD,    32'h4, 32'd4, 0, 0, 0);            // full, below minimum
      send_op(MODE_ADD,    32'h5, 32'd6, 0, 0, 0);            // full, evicts last
      send_op(MODE_RANK,   32'h5, 0, 0, 0, 0);
      send_op(MODE_RANK,   32'h99, 0, 0, 0, 0);               // not found
      send_op(MODE_REMOVE, 32'h99, 0, 0, 0, 0);
      send_op(MODE_SET,    32'h99, 32'd1, 0, 0, 0);
      send_op(MODE_CHANGE, 32'hFFFF_FFFF, 0, 32'd1, 0, 0);    // up at max
      send_op(MODE_CHANGE, 32'h5, 0, 32'd0, 0, 0);            // zero change
      send_op(MODE_CHANGE, 32'h1, 0, -32'd10, 0, 0);          // saturates at zero
      send_op(MODE_CHANGE, 32'h1, 0, 32'h8000_0000, 0, 0);    // down at zero still moves
      send_op(MODE_SET,    32'h5, 32'd6, 0, 0, 0);            // same value
      send_op(MODE_SET,    32'h5, 32'd0, 0, 0, 0);
      send_op(MODE_CHANGE, 32'h1, 0, 32'h7FFF_FFFF, 0, 0);
      send_op(MODE_RANGE,  0, 0, 0, 11'd0, 6'd4);             // begin zero
      send_op(MODE_RANGE,  0, 0, 0, 11'd1, 6'd0);             // count zero
      send_op(MODE_RANGE,  0, 0, 0, 11'h7FF, 6'd1);           // past the end
      send_op(MODE_RANGE,  0, 0, 0, 11'd1, 6'h3F);
      send_op(MODE_RANGE,  0, 0, 0, 11'd2, 6'd1);
      send_op(3'd6,        32'h1, 0, 0, 0, 0);                // ignored
      send_op(3'd7,        32'h1, 0, 0, 0, 0);
      send_op(MODE_REMOVE, 32'hFFFF_FFFF, 0, 0, 0, 0);
      wait_quiet();
   endtask

   // capacity dropped under the count: table stays, adds evict only the last
   task automatic test_capacity_shrink();
      write_capacity(11'd0);   // acts as one
      send_op(MODE_ADD, 32'h20, 32'd0, 0, 0, 0);
      send_op(MODE_ADD, 32'h21, 32'hFFFF_FFF0, 0, 0, 0);
      send_op(MODE_RANGE, 0, 0, 0, 11'd1, 6'd32);
      wait_quiet();
      write_capacity(11'd1);
      send_op(MODE_ADD, 32'h22, 32'd0, 0, 0, 0);
      wait_quiet();
   endtask

   // random phases over several capacities, with one full drain midway
   task automatic test_random();
      logic [10:0] caps [0:6] = '{11'd5, 11'd16, 11'd40, 11'd1024, 11'h7FF, 11'd2, 11'd24};
      for (int p = 0; p < 7; p++) begin
         write_capacity(caps[p]);
         quiet_sender   = (p == 2);
         quiet_receiver = (p == 2 || p == 5);
         for (int i = 0; i < 48; i++) begin
            if (i == 24 && p == 3) begin
               req_if.valid <= 1'b0;
               do @(posedge clock); while (pending_results.size() != 0);
            end
            send_item(pick_op());
         end
         wait_quiet();
      end
      quiet_sender   = 1'b0;
      quiet_receiver = 1'b0;
   endtask

   initial begin
      reset              = 1'b1;
      csr_write          = 1'b0;
      csr_data           = '0;
      req_if.valid       = 1'b0;
      req_if.mode        = '0;
      req_if.key         = '0;
      req_if.new_value   = '0;
      req_if.delta       = '0;
      req_if.range_begin = '0;
      req_if.range_count = '0;
      rsp_if.ready       = 1'b0;
      stall_left         = 0;
      board_count        = 0;
      capacity_reg       = CAP_RESET;
      error_count        = 0;
      items_sent         = 0;
      results_seen       = 0;
      quiet_sender       = 1'b0;
      quiet_receiver     = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_capacity_shrink();
      test_random();

      $display("covered %0d items and %0d results over capacities 0..2047,", items_sent,
               results_seen);
      $display("with ties, saturation, eviction and range reads under random stalls");
      if (error_count == 0) begin
         $display("bounded_sorted_rank_table_tb: done, clean");
      end else begin
         $display("bounded_sorted_rank_table_tb: done, errors");
      end
      $finish;
   end

   // generous watchdog
   initial begin
      #100ms;
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("bounded_sorted_rank_table_tb: done, errors");
      $finish;
   end

endmodule
